@@ src/bba_pkg.sv @@
// Shared types, constants and bit helpers for the bitmap block allocator.
// No dependencies; imported by bba_map and bitmap_block_allocator.
package bba_pkg;

  // Map geometry
  localparam int MAX_BLOCKS    = 4096;
  localparam int MAP_WORD_BITS = 32;
  localparam int MAP_WORDS     = (MAX_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int WADDR_W       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BIT_W         = $clog2(MAP_WORD_BITS);

  // Field widths
  localparam int CFG_W = 13;
  localparam int CMD_W = 2;
  localparam int BLK_W = 12;
  localparam int ST_W  = 2;

  // Number of distinct values granted_block can carry, and the resulting cap on the limit
  localparam int GRANT_SPAN = 4096;
  localparam int LIM_CAP    = (MAX_BLOCKS < GRANT_SPAN) ? MAX_BLOCKS : GRANT_SPAN;
  localparam logic [CFG_W-1:0] LIM_CAP_C = CFG_W'(LIM_CAP);

  // Commands
  localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FORMAT = 2'd2;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

  // Config register indexes
  localparam logic CFG_TOTAL    = 1'b0;
  localparam logic CFG_RESERVED = 1'b1;

  typedef logic [MAP_WORD_BITS-1:0] word_t;
  typedef logic [WADDR_W-1:0]       waddr_t;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [BLK_W-1:0] block_number;
  } req_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [BLK_W-1:0] granted_block;
  } rsp_t;

  // Top cnt bits set (blocks are MSB-first in a word); saturates at a full word
  function automatic word_t lead_mask(input logic [31:0] cnt);
    word_t m;
    if (cnt >= 32'(MAP_WORD_BITS)) begin
      m = '1;
    end else begin
      m = ~(word_t'('1) >> cnt);
    end
    return m;
  endfunction

  // Word bit that holds block offset pos
  function automatic word_t bit_at(input logic [BIT_W-1:0] pos);
    word_t m;
    m = word_t'(1) << (BIT_W'(MAP_WORD_BITS - 1) - pos);
    return m;
  endfunction

  // Offset of the first set bit counted from the MSB (lowest block number)
  function automatic logic [BIT_W-1:0] first_set(input word_t w);
    logic [BIT_W-1:0] pos;
    logic             hit;
    pos = '0;
    hit = 1'b0;
    for (int i = 0; i < MAP_WORD_BITS; i++) begin
      if (!hit && w[MAP_WORD_BITS-1-i]) begin
        pos = BIT_W'(i);
        hit = 1'b1;
      end
    end
    return pos;
  endfunction

endpackage

@@ src/bba_map.sv @@
// Usage map storage: one-port-write, one-port-read word memory with
// registered read data and per-word valid bits so reset reads as all free.
// Depends on bba_pkg.
module bba_map (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            rd_en,
  input  bba_pkg::waddr_t rd_addr,
  output bba_pkg::word_t  rd_data,
  input  logic            wr_en,
  input  bba_pkg::waddr_t wr_addr,
  input  bba_pkg::word_t  wr_data
);
  import bba_pkg::*;

  word_t                mem [MAP_WORDS];
  logic [MAP_WORDS-1:0] valid_r;
  word_t                rd_q_r;
  logic                 rd_vld_r;

  // Memory array, no reset
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  // Word valid bits; a never-written word reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

@@ src/bitmap_block_allocator.sv @@
// Bitmap block allocator top level: request sequencer, config registers and
// result register around the usage map. Depends on bba_pkg and bba_map.
//
//  channel  | signals                       | direction
//  ---------+-------------------------------+----------
//  request  | in_valid, in_ready, in_req    | in
//  result   | out_valid, out_ready, out_rsp | out
//  config   | cfg_we, cfg_index, cfg_wdata  | in
//
// Allocate reads one map word per cycle from word 0 upward and stops at the
// first word with a free block below the limit, or reports full at the limit
// or the last word. Free is a read-modify-write of one word. Format writes
// every map word once; other codes go straight to done. Sync reset empties
// the map at once through the word valid bits. A stalled result holds the
// sequencer in its done state; the next request is taken once it moves on.
module bitmap_block_allocator (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  bba_pkg::req_t                    in_req,
  output logic                             out_valid,
  input  logic                             out_ready,
  output bba_pkg::rsp_t                    out_rsp,
  input  logic                             cfg_we,
  input  logic                             cfg_index,
  input  logic [bba_pkg::CFG_W-1:0]        cfg_wdata
);
  import bba_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_FREE = 3'd2;
  localparam logic [2:0] S_FMT  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [CFG_W-1:0] total_r, reserved_r;
  logic [CFG_W-1:0] lim_r, lim_nxt;
  logic [CFG_W-1:0] res_r, res_nxt;
  logic [BLK_W-1:0] blk_r, blk_nxt;
  waddr_t           chk_r, chk_nxt;
  rsp_t             rsp_r, rsp_nxt;
  logic             out_valid_r;
  rsp_t             out_rsp_r;

  logic   rd_en, wr_en;
  waddr_t rd_addr, wr_addr;
  word_t  rd_data, wr_data;

  logic [CFG_W-1:0] lim_now, res_now;
  logic [31:0]      base32, next_base32, res32;
  word_t            free_bits;
  logic             found;
  logic [BIT_W-1:0] pos;
  logic             accept;

  bba_map u_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // Effective limits from the config registers
  assign lim_now = (total_r > LIM_CAP_C) ? LIM_CAP_C : total_r;
  assign res_now = (32'(reserved_r) > 32'(MAX_BLOCKS)) ? CFG_W'(MAX_BLOCKS) : reserved_r;

  // Word under test: free blocks that lie below the limit
  assign base32      = 32'(chk_r) << BIT_W;
  assign next_base32 = base32 + 32'(MAP_WORD_BITS);
  assign res32       = 32'(res_r);
  assign free_bits   = ~rd_data & lead_mask(32'(lim_r) - base32);
  assign found       = |free_bits;
  assign pos         = first_set(free_bits);

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    lim_nxt   = lim_r;
    res_nxt   = res_r;
    blk_nxt   = blk_r;
    chk_nxt   = chk_r;
    rsp_nxt   = rsp_r;
    rd_en     = 1'b0;
    rd_addr   = '0;
    wr_en     = 1'b0;
    wr_addr   = chk_r;
    wr_data   = rd_data;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          lim_nxt = lim_now;
          res_nxt = res_now;
          blk_nxt = in_req.block_number;
          chk_nxt = '0;
          rsp_nxt = '{status: ST_OK, granted_block: '0};
          priority if (in_req.command == CMD_ALLOC) begin
            if (lim_now == '0) begin
              rsp_nxt.status = ST_FULL;
              state_nxt      = S_DONE;
            end else begin
              rd_en     = 1'b1;
              state_nxt = S_SCAN;
            end
          end else if (in_req.command == CMD_FREE) begin
            if (CFG_W'(in_req.block_number) >= lim_now) begin
              rsp_nxt.status = ST_RANGE;
              state_nxt      = S_DONE;
            end else begin
              rd_en     = 1'b1;
              rd_addr   = WADDR_W'(in_req.block_number >> BIT_W);
              state_nxt = S_FREE;
            end
          end else if (in_req.command == CMD_FORMAT) begin
            state_nxt = S_FMT;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_SCAN: begin
        if (found) begin
          wr_en                 = 1'b1;
          wr_data               = rd_data | bit_at(pos);
          rsp_nxt.granted_block = BLK_W'(base32 + 32'(pos));
          state_nxt             = S_DONE;
        end else if ((32'(chk_r) == 32'(MAP_WORDS - 1)) || (next_base32 >= 32'(lim_r))) begin
          rsp_nxt.status = ST_FULL;
          state_nxt      = S_DONE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = chk_r + 1'b1;
          chk_nxt = chk_r + 1'b1;
        end
      end
      S_FREE: begin
        wr_en     = 1'b1;
        wr_addr   = WADDR_W'(blk_r >> BIT_W);
        wr_data   = rd_data & ~bit_at(blk_r[BIT_W-1:0]);
        state_nxt = S_DONE;
      end
      S_FMT: begin
        // Word fully, partly or not covered by the reserved area
        wr_en   = 1'b1;
        wr_data = (res32 > base32) ? lead_mask(res32 - base32) : '0;
        chk_nxt = chk_r + 1'b1;
        if (32'(chk_r) == 32'(MAP_WORDS - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      total_r     <= CFG_W'(4096);
      reserved_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_TOTAL:    total_r    <= cfg_wdata;
          CFG_RESERVED: reserved_r <= cfg_wdata;
          default:      ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    lim_r <= lim_nxt;
    res_r <= res_nxt;
    blk_r <= blk_nxt;
    chk_r <= chk_nxt;
    rsp_r <= rsp_nxt;
    if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
      out_rsp_r <= rsp_r;
    end
  end

  // A grant is only ever reported with ok status
  a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_rsp.status == ST_OK || out_rsp.granted_block == '0))
    else $error("grant with non-ok status");

  // Granted blocks lie below the limit in force for the request
  a_grant_lim: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && found) |-> (base32 + 32'(pos) < 32'(lim_r)))
    else $error("grant beyond limit");

  // The scan never looks at a word that starts at or beyond the limit
  a_scan_base: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (base32 < 32'(lim_r)))
    else $error("scan past limit");

  // The map is only written by the working states
  a_wr_state: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == S_SCAN || state_r == S_FREE || state_r == S_FMT))
    else $error("map write outside a command");

  // Read and write never collide on one word
  a_rw_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("map read and write on same word");

endmodule
